/* sv/resw_pkg.sv */
// Shared types, constants and the word conversion function of the record endian swapper.
package resw_pkg;

    localparam int WORD_W = 32;
    localparam int LEN_W  = 31;
    localparam int POS_W  = 32;
    localparam int MODE_W = 2;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 32;
    localparam int SLOT_N = 3;
    localparam int CNT_W  = 2;

    localparam logic [WORD_W-1:0] MARK_1234  = 32'h0403_0201;
    localparam logic [WORD_W-1:0] MARK_3412  = 32'h0201_0403;
    localparam logic [WORD_W-1:0] MARK_4321  = 32'h0102_0304;
    localparam logic [WORD_W-1:0] BYTE1_MASK = 32'h0000_FF00;
    localparam logic [WORD_W-1:0] BYTE2_MASK = 32'h00FF_0000;
    localparam logic [POS_W-1:0]  POS_MAX    = '1;

    localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HALF    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FULL    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic [LEN_W-1:0]  given_length;
        logic              first_word;
        logic              last_word;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] out_word;
        logic              out_last;
        logic [MODE_W-1:0] swap_mode;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0]         count;
        result_t [SLOT_N-1:0]     slot;
    } bundle_t;

    function automatic logic [WORD_W-1:0] convert_word(
        input logic [WORD_W-1:0] w,
        input logic [MODE_W-1:0] mode
    );
        logic [WORD_W-1:0] r;
        case (mode)
            MODE_HALF: begin
                r = {w[15:0], w[31:16]};
            end
            MODE_FULL: begin
                r = (w << 24) | ((w << 8) & BYTE2_MASK) | ((w >> 8) & BYTE1_MASK) | (w >> 24);
            end
            default: begin
                r = w;
            end
        endcase
        return r;
    endfunction

endpackage

/* sv/resw_core.sv */
// Record state and per-item result bundle computation of the record endian swapper.
module resw_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  resw_pkg::item_t   item,
    input  logic              fire,
    output resw_pkg::bundle_t bundle
);
    import resw_pkg::*;

    logic [WORD_W-1:0] held_first_reg, held_first_next;
    logic [WORD_W-1:0] held_second_reg, held_second_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [POS_W-1:0]  limit_reg, limit_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    always_comb begin
        logic [POS_W-1:0]  pos;
        logic [CNT_W-1:0]  n;
        logic [MODE_W-1:0] md;
        logic [WORD_W-1:0] c0;
        logic [WORD_W-1:0] c1;
        logic [POS_W-1:0]  lim;
        pos = pos_reg;
        n = '0;
        md = MODE_NONE;
        c0 = '0;
        c1 = '0;
        lim = '0;
        bundle = '0;
        held_first_next = held_first_reg;
        held_second_next = held_second_reg;
        mode_next = mode_reg;
        limit_next = limit_reg;
        len_next = len_reg;
        pos_next = pos_reg;

        if (item.first_word && pos != '0) begin
            if (pos == POS_W'(1)) begin
                bundle.slot[0] = '{held_first_reg, 1'b1, MODE_NONE};
                n = CNT_W'(1);
            end else if (pos == POS_W'(2)) begin
                bundle.slot[0] = '{held_first_reg, 1'b0, MODE_NONE};
                bundle.slot[1] = '{held_second_reg, 1'b1, MODE_NONE};
                n = CNT_W'(2);
            end
            pos = '0;
        end

        if (pos == '0) begin
            len_next = item.given_length;
            if (item.last_word) begin
                bundle.slot[n] = '{item.data_word, 1'b1, MODE_NONE};
                n = n + CNT_W'(1);
                pos_next = '0;
            end else begin
                held_first_next = item.data_word;
                pos_next = POS_W'(1);
            end
        end else if (pos == POS_W'(1)) begin
            if (item.last_word) begin
                bundle.slot[0] = '{held_first_reg, 1'b0, MODE_NONE};
                bundle.slot[1] = '{item.data_word, 1'b1, MODE_NONE};
                n = CNT_W'(2);
                pos_next = '0;
            end else begin
                held_second_next = item.data_word;
                pos_next = POS_W'(2);
            end
        end else if (pos == POS_W'(2)) begin
            if (item.data_word == MARK_1234) begin
                md = MODE_NONE;
            end else if (item.data_word == MARK_3412) begin
                md = MODE_HALF;
            end else if (item.data_word == MARK_4321) begin
                md = MODE_FULL;
            end else begin
                md = MODE_UNKNOWN;
            end
            c0 = convert_word(held_first_reg, md);
            c1 = convert_word(held_second_reg, md);
            lim = (len_reg != '0) ? POS_W'(len_reg) : c1;
            mode_next = md;
            limit_next = lim;
            bundle.slot[0] = '{c0, 1'b0, md};
            bundle.slot[1] = '{c1, 1'b0, md};
            bundle.slot[2] = '{(POS_W'(2) < lim) ? convert_word(item.data_word, md)
                                                 : item.data_word,
                               item.last_word, md};
            n = CNT_W'(3);
            pos_next = item.last_word ? '0 : POS_W'(3);
        end else begin
            bundle.slot[0] = '{(pos < limit_reg) ? convert_word(item.data_word, mode_reg)
                                                 : item.data_word,
                               item.last_word, mode_reg};
            n = CNT_W'(1);
            if (item.last_word) begin
                pos_next = '0;
            end else if (pos != POS_MAX) begin
                pos_next = pos + POS_W'(1);
            end
        end
        bundle.count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_first_reg <= '0;
            held_second_reg <= '0;
            pos_reg <= '0;
            mode_reg <= MODE_NONE;
            limit_reg <= '0;
            len_reg <= '0;
        end else if (fire) begin
            held_first_reg <= held_first_next;
            held_second_reg <= held_second_next;
            pos_reg <= pos_next;
            mode_reg <= mode_next;
            limit_reg <= limit_next;
            len_reg <= len_next;
        end
    end

endmodule

/* sv/resw_out.sv */
// Result bundle register and output serializer of the record endian swapper.
module resw_out (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  resw_pkg::bundle_t              bundle,
    input  logic                           load,
    output logic                           load_ok,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [resw_pkg::M_TDATA_W-1:0] m_tdata,  // out_word
    output logic                           m_tlast,  // out_last
    output logic [resw_pkg::MODE_W-1:0]    m_tuser   // swap_mode
);
    import resw_pkg::*;

    bundle_t          bundle_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             valid_reg;
    logic             at_end;

    assign at_end   = (idx_reg == bundle_reg.count - CNT_W'(1));
    assign load_ok  = !valid_reg || (m_tready && at_end);
    assign m_tvalid = valid_reg;
    assign m_tdata  = bundle_reg.slot[idx_reg].out_word;
    assign m_tlast  = bundle_reg.slot[idx_reg].out_last;
    assign m_tuser  = bundle_reg.slot[idx_reg].swap_mode;

    always_ff @(posedge aclk) begin
        if (load) begin
            bundle_reg <= bundle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg <= '0;
        end else if (valid_reg && m_tready) begin
            if (at_end) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

endmodule

/* sv/record_endian_swapper.sv */
// Top level of the record endian swapper: input register, record logic and output serializer.
// Each word of a record is taken into an input register and processed in one pass into a
// bundle of up to three result items, which the output stage hands out one per cycle while
// m_tready is high. Words 0 and 1 give no result unless the record ends there; word 2 (the
// byte-order marker) gives three, so the input stalls while they go out. Every later word
// gives one item, one word per cycle when the output is ready; the serializer sets this rate.
module record_endian_swapper (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [resw_pkg::S_TDATA_W-1:0] s_tdata,  // data_word, given_length, zero pad
    input  logic                           s_tlast,  // last_word
    input  logic                           s_tuser,  // first_word
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [resw_pkg::M_TDATA_W-1:0] m_tdata,  // out_word
    output logic                           m_tlast,  // out_last
    output logic [resw_pkg::MODE_W-1:0]    m_tuser   // swap_mode
);
    import resw_pkg::*;

    item_t   item_reg;
    logic    in_valid_reg;
    bundle_t bundle;
    logic    load_ok;
    logic    fire;
    logic    load;

    assign fire     = in_valid_reg && (load_ok || bundle.count == '0);
    assign load     = fire && bundle.count != '0;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.data_word    <= s_tdata[WORD_W-1:0];
            item_reg.given_length <= s_tdata[WORD_W+LEN_W-1:WORD_W];
            item_reg.first_word   <= s_tuser;
            item_reg.last_word    <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    resw_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item_reg),
        .fire    (fire),
        .bundle  (bundle)
    );

    resw_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .bundle   (bundle),
        .load     (load),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
